/* rtl/asr_pkg.sv */
// Package for the stump reweighting block: command codes, status codes and
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asr_pkg;
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_EPS_ZERO = 2'd1,
        ST_EPS_ONE  = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    localparam logic [24:0] ONE_Q24   = 25'd16777216;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [23:0] ALPHA_MAX = 24'h7FFFFF;
    localparam logic [23:0] ALPHA_MIN = 24'h800000;
    localparam int          SUM_W     = 41;
endpackage
`default_nettype wire

/* rtl/asr_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
// Does not use asr_pkg; self-contained.
`timescale 1ns / 1ps
`default_nettype none
module asr_divider #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 41
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   n_try;
    logic [DEN_W:0]   n_sh;

    assign n_sh  = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign n_try = n_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                if (!n_try[DEN_W]) begin
                    r_rem <= n_try;
                    r_num <= {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_num;
endmodule
`default_nettype wire

/* rtl/adaboost_stump_reweight.sv */
// Top level of the stump reweighting block: sample and weight memories,
// error pass, log2 unit, reweight pass. Uses asr_pkg and asr_divider.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive i_command and the payload with start high while busy is
// low; the beat is taken at that edge. Clear and load keep busy low and
// give no result. Evaluate gives one result, shown for exactly one cycle
// with o_valid high; the receiver cannot stall it. Evaluate runs an
// optional uniform-weight pass (one division, then one write per sample),
// a sum pass, two log2 evaluations, alpha, then the eps division and a
// reweight pass with one division per sample; every quotient comes from
// the shared bit-serial divider. If the miss or hit sum is zero, the
// result saturates and the log2, alpha, eps and reweight steps are
// skipped. busy drops in the cycle the result is shown, so the next beat
// may be taken in that cycle. The sum pass reads one memory entry per
// cycle; each read word is registered in the cycle after its address.
// Reset empties the sample set and marks the weights for reinitialization;
// the memories themselves hold no reset value and need no clearing pass.
module adaboost_stump_reweight #(
    parameter int SAMPLES  = 256,
    parameter int FEATURES = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_sample_class,
    input  wire logic signed [15:0] i_feature_zero,
    input  wire logic signed [15:0] i_feature_one,
    input  wire logic        i_stump_feature,
    input  wire logic [3:0]  i_stump_class,
    input  wire logic signed [15:0] i_stump_threshold,
    output logic             o_valid,
    output logic signed [23:0] o_stump_weight,
    output logic [24:0]      o_weighted_error,
    output logic [8:0]       o_error_count,
    output logic [1:0]       o_status
);
    localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CW = $clog2(SAMPLES + 1);
    localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int SW = asr_pkg::SUM_W;
    localparam int DW = 66;

    typedef enum logic [3:0] {
        S_IDLE, S_UNIF_DIV, S_UNIF, S_SUM, S_SUM_LAST, S_LOG_INIT, S_LOG,
        S_ALPHA, S_EPS, S_RW_RD, S_RW_DIV, S_RW_WR, S_OUT
    } t_state;

    logic [3+16*FEATURES:0] mem_s [SAMPLES];
    logic [24:0]            mem_w [SAMPLES];
    logic [3+16*FEATURES:0] r_rd_s;
    logic [24:0]            r_rd_w;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic              r_stale;
    logic [CW-1:0]     r_idx;
    logic              r_rd_ok;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [FW-1:0]     r_feat;
    logic [3:0]        r_cls;
    logic signed [15:0] r_thr;
    logic [24:0]       r_unif;
    logic [SW-1:0]     r_msum, r_hsum;
    logic [8:0]        r_err;
    logic              r_lsel;
    logic [5:0]        r_k;
    logic [31:0]       r_m;
    logic [4:0]        r_step;
    logic [29:0]       r_lfrac;
    logic [29:0]       r_lh, r_lm;
    logic [63:0]       r_sq;
    logic              r_sq_ph;
    logic [23:0]       r_alpha;
    logic [24:0]       r_eps;
    logic [1:0]        r_status;

    logic              div_start, div_done;
    logic [DW-1:0]     div_num, div_quot;
    logic [SW-1:0]     div_den;

    asr_divider #(.NUM_W(DW), .DEN_W(SW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    // Miss test on the registered memory word.
    logic signed [15:0] n_v;
    logic               n_miss;
    logic [3:0]         n_rcls;
    always_comb begin
        n_rcls = r_rd_s[3:0];
        n_v    = r_rd_s[4 + 16*r_feat +: 16];
        n_miss = (n_v < r_thr) ? (n_rcls != r_cls) : (n_rcls == r_cls);
    end

    logic [SW-1:0] n_lx;
    logic [5:0]    n_lk;
    always_comb begin
        n_lx = r_lsel ? r_msum : r_hsum;
        n_lk = '0;
        for (int b = 0; b < SW; b++) begin
            if (n_lx[b]) n_lk = 6'(b);
        end
    end

    logic [29:0] n_d;
    logic        n_neg;
    logic [62:0] n_prod;
    logic [22:0] n_mag;
    assign n_neg  = r_lm > r_lh;
    assign n_d    = n_neg ? r_lm - r_lh : r_lh - r_lm;
    assign n_prod = 63'(r_sq);
    assign n_mag  = 23'((n_prod + (63'd1 << 40)) >> 41);

    logic [SW-1:0] n_tsum;
    assign n_tsum = r_msum + r_hsum;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_IDLE: begin
                div_num   = DW'(asr_pkg::ONE_Q24);
                div_den   = SW'(r_count);
                div_start = start && (i_command == asr_pkg::CMD_EVAL) && r_stale
                            && (r_count != '0);
            end
            S_ALPHA: begin
                div_num   = (DW'(r_msum) << 24) + DW'(n_tsum >> 1);
                div_den   = n_tsum;
                div_start = r_sq_ph;
            end
            S_RW_RD: begin
                div_num   = DW'(r_rd_w) << 23;
                div_den   = n_miss ? r_msum : r_hsum;
                div_start = r_rd_vld;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_s <= mem_s[r_rd_idx];
        r_rd_w <= mem_w[r_rd_idx];
        if (start && !busy && (i_command == asr_pkg::CMD_LOAD) && (r_count < CW'(SAMPLES))) begin
            mem_s[r_count[AW-1:0]] <= (FEATURES > 1)
                ? (4+16*FEATURES)'({i_feature_one, i_feature_zero, i_sample_class})
                : (4+16*FEATURES)'({i_feature_zero, i_sample_class});
        end
        if (r_state == S_UNIF) begin
            mem_w[r_idx[AW-1:0]] <= r_unif;
        end else if (r_state == S_RW_WR && div_done) begin
            mem_w[r_rd_idx] <= div_quot[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_stale  <= 1'b1;
            o_valid  <= 1'b0;
            r_idx    <= '0;
            r_rd_idx <= '0;
            r_rd_ok  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_rd_vld <= r_rd_ok;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_command)
                            asr_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_stale <= 1'b1;
                            end
                            asr_pkg::CMD_LOAD: begin
                                if (r_count < CW'(SAMPLES)) begin
                                    r_count <= r_count + 1'b1;
                                    r_stale <= 1'b1;
                                end
                            end
                            asr_pkg::CMD_EVAL: begin
                                r_feat <= (FEATURES > 1 && 32'(i_stump_feature) < FEATURES)
                                          ? FW'(i_stump_feature) : '0;
                                r_cls  <= i_stump_class;
                                r_thr  <= i_stump_threshold;
                                r_msum <= '0;
                                r_hsum <= '0;
                                r_err  <= '0;
                                r_idx  <= '0;
                                r_rd_idx <= '0;
                                if (r_stale && r_count != '0) r_state <= S_UNIF_DIV;
                                else r_state <= S_SUM;
                                r_stale <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_UNIF_DIV: begin
                    if (div_done) begin
                        r_unif  <= div_quot[24:0];
                        r_state <= S_UNIF;
                    end
                end
                S_UNIF: begin
                    if (r_idx + 1'b1 == r_count) begin
                        r_idx   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SUM: begin
                    // Address goes to r_rd_idx with r_rd_ok; the word in r_rd_s is used when r_rd_vld follows.
                    if (r_rd_vld) begin
                        if (n_miss) begin
                            r_msum <= r_msum + SW'(r_rd_w);
                            r_err  <= r_err + 1'b1;
                        end else begin
                            r_hsum <= r_hsum + SW'(r_rd_w);
                        end
                    end
                    if (r_idx < r_count) begin
                        r_rd_idx <= r_idx[AW-1:0];
                        r_rd_ok  <= 1'b1;
                        r_idx    <= r_idx + 1'b1;
                    end else if (!r_rd_ok && !r_rd_vld) begin
                        r_state <= S_SUM_LAST;
                    end
                end
                S_SUM_LAST: begin
                    if (r_msum == '0) begin
                        r_status <= asr_pkg::ST_EPS_ZERO;
                        r_alpha  <= asr_pkg::ALPHA_MAX;
                        r_eps    <= '0;
                        r_state  <= S_OUT;
                    end else if (r_hsum == '0) begin
                        r_status <= asr_pkg::ST_EPS_ONE;
                        r_alpha  <= asr_pkg::ALPHA_MIN;
                        r_eps    <= asr_pkg::ONE_Q24;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= asr_pkg::ST_NORMAL;
                        r_lsel   <= 1'b0;
                        r_state  <= S_LOG_INIT;
                    end
                end
                S_LOG_INIT: begin
                    r_k     <= n_lk;
                    r_m     <= (n_lk <= 6'd30) ? 32'(n_lx << (6'd30 - n_lk))
                                               : 32'(n_lx >> (n_lk - 6'd30));
                    r_step  <= '0;
                    r_lfrac <= '0;
                    r_sq_ph <= 1'b0;
                    r_state <= S_LOG;
                end
                S_LOG: begin
                    // Square while r_sq_ph is low, normalize while it is high.
                    if (!r_sq_ph) begin
                        r_sq    <= r_m * r_m;
                        r_sq_ph <= 1'b1;
                    end else begin
                        r_sq_ph <= 1'b0;
                        if (r_sq[61]) begin
                            r_m     <= 32'(r_sq >> 31);
                            r_lfrac <= {r_lfrac[28:0], 1'b1};
                        end else begin
                            r_m     <= 32'(r_sq >> 30);
                            r_lfrac <= {r_lfrac[28:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                        if (r_step == 5'd23) begin
                            if (!r_lsel) begin
                                r_lh    <= {r_k, r_lfrac[22:0], r_sq[61]};
                                r_lsel  <= 1'b1;
                                r_state <= S_LOG_INIT;
                            end else begin
                                r_lm    <= {r_k, r_lfrac[22:0], r_sq[61]};
                                r_state <= S_ALPHA;
                            end
                        end
                    end
                end
                S_ALPHA: begin
                    if (!r_sq_ph) begin
                        r_sq    <= 64'(n_d) * 64'(asr_pkg::LN2_Q32);
                        r_sq_ph <= 1'b1;
                    end else begin
                        r_alpha <= n_neg ? 24'(-$signed({1'b0, n_mag}))
                                         : {1'b0, n_mag};
                        r_state <= S_EPS;
                    end
                end
                S_EPS: begin
                    if (div_done) begin
                        r_eps    <= div_quot[24:0];
                        r_idx    <= '0;
                        r_state  <= S_RW_RD;
                        r_rd_idx <= '0;
                    end
                end
                S_RW_RD: begin
                    if (r_rd_vld) begin
                        r_state <= S_RW_WR;
                    end else if (!r_rd_ok) begin
                        if (r_idx < r_count) begin
                            r_rd_idx <= r_idx[AW-1:0];
                            r_rd_ok  <= 1'b1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RW_WR: begin
                    if (div_done) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RW_RD;
                    end
                end
                S_OUT: begin
                    o_valid          <= 1'b1;
                    o_stump_weight   <= r_alpha;
                    o_weighted_error <= r_eps;
                    o_error_count    <= r_err;
                    o_status         <= r_status;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SAMPLES)) else $error("sample count past capacity");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result shown twice");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while still busy");
    a_sat_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == asr_pkg::ST_EPS_ZERO) |-> o_weighted_error == '0)
        else $error("eps zero flag with nonzero eps");
`endif
endmodule
`default_nettype wire

/* dv/adaboost_stump_reweight_tb.sv */
// Self-checking testbench for adaboost_stump_reweight: directed and random beats,
// with a built-in stump error and reweight predictor. Depends on rtl/asr_pkg.sv.
// Reset is asserted once, and a watchdog ends the run if no beat is accepted and no result is shown.
`timescale 1ns / 1ps
module adaboost_stump_reweight_tb;

    localparam int CAP       = 256;
    localparam int WDOG_MAX  = 100000;

    typedef struct {
        logic signed [23:0] alpha;
        logic [24:0]        eps;
        logic [8:0]         misses;
        asr_pkg::t_status   status;
    } t_stump_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = asr_pkg::CMD_NONE;
    logic [3:0]  i_sample_class = '0;
    logic signed [15:0] i_feature_zero = '0;
    logic signed [15:0] i_feature_one = '0;
    logic        i_stump_feature = 1'b0;
    logic [3:0]  i_stump_class = '0;
    logic signed [15:0] i_stump_threshold = '0;
    logic        o_valid;
    logic signed [23:0] o_stump_weight;
    logic [24:0] o_weighted_error;
    logic [8:0]  o_error_count;
    logic [1:0]  o_status;

    adaboost_stump_reweight i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_sample_class(i_sample_class),
        .i_feature_zero(i_feature_zero), .i_feature_one(i_feature_one),
        .i_stump_feature(i_stump_feature), .i_stump_class(i_stump_class),
        .i_stump_threshold(i_stump_threshold), .o_valid(o_valid),
        .o_stump_weight(o_stump_weight), .o_weighted_error(o_weighted_error),
        .o_error_count(o_error_count), .o_status(o_status)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [3:0]         pm_class [CAP];
    logic signed [15:0] pm_feat0 [CAP];
    logic signed [15:0] pm_feat1 [CAP];
    logic [31:0]        pm_weight [CAP];
    int                 pm_count;
    bit                 pm_stale;

    t_stump_result pending_results[$];
    int  error_total;
    int  beats_sent;
    int  results_seen;
    int  idle_cycles;
    bit  timed_out;

    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int k;
        logic [63:0] m;
        logic [63:0] fr;
        k = 0;
        fr = '0;
        while (k < 63 && (x >> (k + 1)) != 0) k++;
        m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                fr = fr | 64'd1;
            end
        end
        return (64'(k) << 24) | fr;
    endfunction

    task automatic predict_beat(input asr_pkg::t_cmd cmd, input logic [3:0] cls,
                                input logic signed [15:0] f0, input logic signed [15:0] f1,
                                input logic sf, input logic [3:0] sc,
                                input logic signed [15:0] thr);
        logic [63:0] msum, hsum, tsum, lh, lm, d, mag;
        logic signed [15:0] v;
        bit miss [CAP];
        bit neg;
        int misses;
        t_stump_result r;
        msum = 0;
        hsum = 0;
        misses = 0;
        case (cmd)
            asr_pkg::CMD_CLEAR: begin
                pm_count = 0;
                pm_stale = 1;
            end
            asr_pkg::CMD_LOAD: begin
                if (pm_count < CAP) begin
                    pm_class[pm_count] = cls;
                    pm_feat0[pm_count] = f0;
                    pm_feat1[pm_count] = f1;
                    pm_count++;
                    pm_stale = 1;
                end
            end
            asr_pkg::CMD_EVAL: begin
                if (pm_stale && pm_count > 0)
                    for (int i = 0; i < pm_count; i++)
                        pm_weight[i] = 32'(64'(asr_pkg::ONE_Q24) / pm_count);
                pm_stale = 0;
                for (int i = 0; i < pm_count; i++) begin
                    v = sf ? pm_feat1[i] : pm_feat0[i];
                    miss[i] = (v < thr) ? (pm_class[i] != sc) : (pm_class[i] == sc);
                    if (miss[i]) begin
                        misses++;
                        msum += pm_weight[i];
                    end else begin
                        hsum += pm_weight[i];
                    end
                end
                tsum = msum + hsum;
                r.misses = misses[8:0];
                if (msum == 0) begin
                    r.status = asr_pkg::ST_EPS_ZERO;
                    r.alpha = asr_pkg::ALPHA_MAX;
                    r.eps = '0;
                end else if (hsum == 0) begin
                    r.status = asr_pkg::ST_EPS_ONE;
                    r.alpha = asr_pkg::ALPHA_MIN;
                    r.eps = asr_pkg::ONE_Q24;
                end else begin
                    lh = log2_fix(hsum);
                    lm = log2_fix(msum);
                    neg = lm > lh;
                    d = neg ? lm - lh : lh - lm;
                    mag = (d * 64'(asr_pkg::LN2_Q32) + (64'd1 << 40)) >> 41;
                    if (mag > 64'(asr_pkg::ALPHA_MAX)) mag = 64'(asr_pkg::ALPHA_MAX);
                    r.alpha = neg ? -24'(mag) : 24'(mag);
                    r.status = asr_pkg::ST_NORMAL;
                    r.eps = 25'(((msum << 24) + tsum / 2) / tsum);
                    for (int i = 0; i < pm_count; i++)
                        pm_weight[i] = 32'((64'(pm_weight[i]) << 23) / (miss[i] ? msum : hsum));
                end
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Drives one beat; start is left high so back-to-back beats need no toggle.
    task automatic send_beat(input asr_pkg::t_cmd cmd, input logic [3:0] cls,
                             input logic signed [15:0] f0, input logic signed [15:0] f1,
                             input logic sf, input logic [3:0] sc,
                             input logic signed [15:0] thr);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_sample_class <= cls;
        i_feature_zero <= f0;
        i_feature_one <= f1;
        i_stump_feature <= sf;
        i_stump_class <= sc;
        i_stump_threshold <= thr;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        beats_sent++;
        predict_beat(cmd, cls, f0, f1, sf, sc, thr);
    endtask

    task automatic load_sample(input logic [3:0] cls, input logic signed [15:0] f0,
                               input logic signed [15:0] f1);
        send_beat(asr_pkg::CMD_LOAD, cls, f0, f1, 1'($urandom), 4'($urandom),
                  16'($urandom));
    endtask

    task automatic eval_stump(input logic sf, input logic [3:0] sc,
                              input logic signed [15:0] thr);
        send_beat(asr_pkg::CMD_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                  sf, sc, thr);
    endtask

    task automatic clear_samples();
        send_beat(asr_pkg::CMD_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_total++;
    endtask

    // Result checker: the receiver cannot stall, so every strobe is a beat.
    always @(posedge i_clk) begin
        t_stump_result r;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_status), 64'd0);
            end else begin
                r = pending_results.pop_front();
                if (o_stump_weight !== r.alpha)
                    report_mismatch("stump_weight", 64'(o_stump_weight), 64'(r.alpha));
                if (o_weighted_error !== r.eps)
                    report_mismatch("weighted_error", 64'(o_weighted_error), 64'(r.eps));
                if (o_error_count !== r.misses)
                    report_mismatch("error_count", 64'(o_error_count), 64'(r.misses));
                if (o_status !== r.status)
                    report_mismatch("status", 64'(o_status), 64'(r.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("adaboost_stump_reweight regression: fail");
            $finish;
        end
    end

    task automatic test_empty_set();
        clear_samples();
        eval_stump(1'b0, 4'd0, 16'sd0);
        eval_stump(1'b1, 4'd15, -16'sd32768);
    endtask

    task automatic test_extremes();
        clear_samples();
        load_sample(4'd0, -16'sd32768, 16'sd32767);
        load_sample(4'd15, 16'sd32767, -16'sd32768);
        load_sample(4'd5, 16'sd0, 16'sd0);
        load_sample(4'd0, 16'sd255, -16'sd1);
        eval_stump(1'b0, 4'd0, -16'sd32768);
        eval_stump(1'b0, 4'd0, 16'sd32767);
        eval_stump(1'b1, 4'd15, 16'sd0);
        // All stored samples sit at or above the threshold; the first stump matches their class, the second does not.
        clear_samples();
        load_sample(4'd3, 16'sd100, 16'sd100);
        load_sample(4'd3, 16'sd200, 16'sd200);
        eval_stump(1'b0, 4'd3, -16'sd32768);
        eval_stump(1'b1, 4'd7, -16'sd32768);
    endtask

    task automatic test_unused_command();
        send_beat(asr_pkg::CMD_NONE, 4'hF, -16'sd1, -16'sd1, 1'b1, 4'hF, -16'sd1);
        eval_stump(1'b1, 4'd3, 16'sd150);
    endtask

    task automatic test_full_store();
        clear_samples();
        for (int i = 0; i <= CAP; i++)
            load_sample(4'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        eval_stump(1'b0, 4'd1, 16'($urandom));
        eval_stump(1'b1, 4'd2, 16'sd0);
    endtask

    task automatic test_random(input int beats_target);
        int n, evals, pick;
        logic signed [15:0] thr;
        while (beats_sent < beats_target) begin
            if ($urandom_range(0, 4) != 0) clear_samples();
            n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            for (int i = 0; i < n; i++)
                load_sample($urandom_range(0, 5) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3)),
                            16'($urandom), 16'($urandom));
            evals = $urandom_range(1, 6);
            for (int e = 0; e < evals; e++) begin
                pick = $urandom_range(0, pm_count > 0 ? pm_count - 1 : 0);
                thr = ($urandom_range(0, 2) != 0 && pm_count > 0)
                      ? pm_feat0[pick] + 16'($urandom_range(0, 1)) : 16'($urandom);
                eval_stump(1'($urandom),
                           $urandom_range(0, 4) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3)),
                           thr);
                if ($urandom_range(0, 15) == 0)
                    send_beat(asr_pkg::CMD_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                              1'($urandom), 4'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        error_total = 0;
        beats_sent = 0;
        results_seen = 0;
        timed_out = 0;
        pm_count = 0;
        pm_stale = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_extremes();
        test_unused_command();
        test_full_store();
        test_random(580);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d beats, checked %0d stump results, %0d mismatches.",
                 beats_sent, results_seen, error_total);
        if (error_total == 0 && pending_results.size() == 0) begin
            $display("adaboost_stump_reweight regression: pass");
        end else begin
            $display("adaboost_stump_reweight regression: fail");
        end
        $finish;
    end
endmodule

/* adaboost_stump_reweight.f */
rtl/asr_pkg.sv
rtl/asr_divider.sv
rtl/adaboost_stump_reweight.sv
dv/adaboost_stump_reweight_tb.sv
